>>> rtl/dcs_pkg.sv
// Shared types, codes and the control store of the drive command sequencer.
package dcs_pkg;

    localparam logic [8:0]        NEUTRAL_COMPARE = 9'd250;
    localparam logic signed [10:0] RAMP_STEP      = 11'sd10;
    localparam logic [8:0]        TRIM            = 9'd10;
    localparam logic [15:0]       PULSE_MS        = 16'd100;
    localparam logic [15:0]       HORN_MS         = 16'd1000;
    // Ceiling to whole 100 ms: floor((d + 99) * TURN_RECIP / 2^24) equals
    // floor((d + 99) / 100) over the full 16-bit range of d.
    localparam logic [16:0]       TURN_ROUND      = 17'd99;
    localparam logic [17:0]       TURN_RECIP      = 18'd167773;

    localparam logic [7:0] CMD_STOP    = 8'h00;
    localparam logic [7:0] CMD_FORWARD = 8'h01;
    localparam logic [7:0] CMD_RIGHT   = 8'h02;
    localparam logic [7:0] CMD_REVERSE = 8'h03;
    localparam logic [7:0] CMD_LEFT    = 8'h04;
    localparam logic [7:0] CMD_FASTER  = 8'h05;
    localparam logic [7:0] CMD_SLOWER  = 8'h06;
    localparam logic [7:0] CMD_HORN    = 8'h07;
    localparam logic [7:0] CMD_SPD_RST = 8'h09;

    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_FORWARD = 3'd1;
    localparam logic [2:0] MODE_RIGHT   = 3'd2;
    localparam logic [2:0] MODE_REVERSE = 3'd3;
    localparam logic [2:0] MODE_LEFT    = 3'd4;

    localparam logic [2:0] REG_FORWARD_DRIVE = 3'd0;
    localparam logic [2:0] REG_REVERSE_DRIVE = 3'd1;
    localparam logic [2:0] REG_LEFT_STEER    = 3'd2;
    localparam logic [2:0] REG_RIGHT_STEER   = 3'd3;
    localparam logic [2:0] REG_LEFT_PIVOT    = 3'd4;
    localparam logic [2:0] REG_RIGHT_PIVOT   = 3'd5;
    localparam logic [2:0] REG_TURN_MS       = 3'd6;
    localparam logic [2:0] REG_RAMP_MS       = 3'd7;

    typedef enum logic [2:0] {
        ACT_STEER  = 3'd0,
        ACT_DRIVE  = 3'd1,
        ACT_FASTER = 3'd2,
        ACT_SLOWER = 3'd3,
        ACT_HORN   = 3'd4,
        ACT_REPORT = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        OP_EMIT   = 2'd0,
        OP_RAMP   = 2'd1,
        OP_JUMP   = 2'd2,
        OP_REPORT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMP_ZERO     = 3'd0,
        CMP_NEUTRAL  = 3'd1,
        CMP_FORWARD  = 3'd2,
        CMP_REVERSE  = 3'd3,
        CMP_STEER    = 3'd4,
        CMP_FWD_TRIM = 3'd5,
        CMP_REV_TRIM = 3'd6
    } t_cmp_sel;

    typedef enum logic [1:0] {
        HOLD_ZERO  = 2'd0,
        HOLD_PULSE = 2'd1,
        HOLD_HORN  = 2'd2,
        HOLD_TURN  = 2'd3
    } t_hold_sel;

    typedef enum logic [1:0] {
        RAMP_TO_TURN    = 2'd0,
        RAMP_FROM_TURN  = 2'd1,
        RAMP_TO_PIVOT   = 2'd2
    } t_ramp_sel;

    typedef struct packed {
        t_op       op;
        t_action   action;
        t_cmp_sel  cmp_sel;
        t_hold_sel hold_sel;
        t_ramp_sel ramp_sel;
    } t_ctrl;

    // Entry points of the control store.
    localparam logic [5:0] ENT_PREFIX     = 6'd0;
    localparam logic [5:0] ENT_STOP       = 6'd3;
    localparam logic [5:0] ENT_REPORT     = 6'd5;
    localparam logic [5:0] ENT_FORWARD    = 6'd6;
    localparam logic [5:0] ENT_REVERSE    = 6'd9;
    localparam logic [5:0] ENT_TURN_FWD   = 6'd12;
    localparam logic [5:0] ENT_TURN_REV   = 6'd17;
    localparam logic [5:0] ENT_PIVOT      = 6'd22;
    localparam logic [5:0] ENT_TURN_STILL = 6'd24;
    localparam logic [5:0] ENT_FASTER     = 6'd27;
    localparam logic [5:0] ENT_SPD_RST    = 6'd29;
    localparam logic [5:0] ENT_SLOWER     = 6'd31;
    localparam logic [5:0] ENT_HORN       = 6'd33;

    function automatic t_ctrl f_word(input t_op op, input t_action act,
                                     input t_cmp_sel cmp, input t_hold_sel hold,
                                     input t_ramp_sel rs);
        t_ctrl w;
        w.op       = op;
        w.action   = act;
        w.cmp_sel  = cmp;
        w.hold_sel = hold;
        w.ramp_sel = rs;
        return w;
    endfunction

    function automatic t_ctrl f_emit(input t_action act, input t_cmp_sel cmp,
                                     input t_hold_sel hold);
        return f_word(OP_EMIT, act, cmp, hold, RAMP_TO_TURN);
    endfunction

    function automatic t_ctrl f_ramp(input t_ramp_sel rs);
        return f_word(OP_RAMP, ACT_STEER, CMP_ZERO, HOLD_ZERO, rs);
    endfunction

    localparam t_ctrl W_REPORT = '{OP_REPORT, ACT_REPORT, CMP_ZERO, HOLD_ZERO, RAMP_TO_TURN};
    localparam t_ctrl W_JUMP   = '{OP_JUMP, ACT_REPORT, CMP_ZERO, HOLD_ZERO, RAMP_TO_TURN};

    // Control store: one word per step.
    function automatic t_ctrl f_ucode(input logic [5:0] pc);
        t_ctrl w;
        unique case (pc)
            // Obstacle while moving forward: stop first, then the command.
            6'd0:  w = f_emit(ACT_STEER, CMP_NEUTRAL, HOLD_ZERO);
            6'd1:  w = f_emit(ACT_DRIVE, CMP_NEUTRAL, HOLD_ZERO);
            6'd2:  w = W_JUMP;
            // Stop.
            6'd3:  w = f_emit(ACT_STEER, CMP_NEUTRAL, HOLD_ZERO);
            6'd4:  w = f_emit(ACT_DRIVE, CMP_NEUTRAL, HOLD_ZERO);
            6'd5:  w = W_REPORT;
            // Forward start.
            6'd6:  w = f_emit(ACT_STEER, CMP_NEUTRAL, HOLD_ZERO);
            6'd7:  w = f_emit(ACT_DRIVE, CMP_FORWARD, HOLD_ZERO);
            6'd8:  w = W_REPORT;
            // Reverse drive write.
            6'd9:  w = f_emit(ACT_STEER, CMP_NEUTRAL, HOLD_ZERO);
            6'd10: w = f_emit(ACT_DRIVE, CMP_REVERSE, HOLD_ZERO);
            6'd11: w = W_REPORT;
            // Turn while driving forward.
            6'd12: w = f_ramp(RAMP_TO_TURN);
            6'd13: w = f_emit(ACT_DRIVE, CMP_FWD_TRIM, HOLD_TURN);
            6'd14: w = f_ramp(RAMP_FROM_TURN);
            6'd15: w = f_emit(ACT_DRIVE, CMP_FORWARD, HOLD_ZERO);
            6'd16: w = W_REPORT;
            // Turn while reversing.
            6'd17: w = f_emit(ACT_STEER, CMP_STEER, HOLD_ZERO);
            6'd18: w = f_emit(ACT_DRIVE, CMP_REV_TRIM, HOLD_TURN);
            6'd19: w = f_emit(ACT_STEER, CMP_NEUTRAL, HOLD_ZERO);
            6'd20: w = f_emit(ACT_DRIVE, CMP_REVERSE, HOLD_ZERO);
            6'd21: w = W_REPORT;
            // Pivot from standstill at the lowest rank.
            6'd22: w = f_ramp(RAMP_TO_PIVOT);
            6'd23: w = W_REPORT;
            // Turn from any other state.
            6'd24: w = f_emit(ACT_STEER, CMP_STEER, HOLD_ZERO);
            6'd25: w = f_emit(ACT_DRIVE, CMP_NEUTRAL, HOLD_ZERO);
            6'd26: w = W_REPORT;
            6'd27: w = f_emit(ACT_FASTER, CMP_ZERO, HOLD_PULSE);
            6'd28: w = W_REPORT;
            // Speed reset runs three slower pulses and shares the tail.
            6'd29: w = f_emit(ACT_SLOWER, CMP_ZERO, HOLD_PULSE);
            6'd30: w = f_emit(ACT_SLOWER, CMP_ZERO, HOLD_PULSE);
            6'd31: w = f_emit(ACT_SLOWER, CMP_ZERO, HOLD_PULSE);
            6'd32: w = W_REPORT;
            6'd33: w = f_emit(ACT_HORN, CMP_ZERO, HOLD_HORN);
            6'd34: w = W_REPORT;
            default: w = W_REPORT;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/drive_command_sequencer.sv
// Drive command sequencer: microcoded action generator for a small motor drive.
//
// Usage: each transfer on the s_axis channel carries one command byte and the
// obstacle flag. The block answers with a run of actions on the m_axis channel
// (steer or drive compare writes, speed and horn pulses), each with the time
// to wait after it, and always closes the run with a report item that has
// tlast set. Every item of a run carries the motion mode, speed rank and LED
// toggle as they stand after the command.
// Sequencing: a command is taken while the block idles, then the control
// words run in order. Each action is one step, the obstacle stop prefix
// adds a jump step, and each steering ramp adds a step to set up and one
// to finish. The next command is taken only after the report item has been
// placed in the output register.
// Reset sets the configuration and control registers to their defaults,
// mode stop and rank one; the output payload registers are not reset.
// If the receiver stalls, the sequencer holds on the current action; nothing
// is dropped or repeated. Configuration is to be written on the plain register
// port only while the block idles; the block itself does not enforce this.
module drive_command_sequencer
    import dcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] command, [8] obstacle, [15:9] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [8:0] compare_value, [24:9] hold_ms,
                                        // [27:25] motion_mode, [43:28] speed_level,
                                        // [44] led_toggle, [47:45] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] action
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic [8:0]  r_fwd_drive, r_rev_drive, r_left_steer, r_right_steer;
    logic [8:0]  r_left_pivot, r_right_pivot;
    logic [15:0] r_turn_ms;
    logic [7:0]  r_ramp_ms;

    // Turn hold, rounded up to 100 ms, in two registered steps.
    logic [34:0] w_turn_prod;
    logic [9:0]  r_turn_q;
    logic [16:0] w_turn_scaled;
    logic [15:0] r_turn_hold;

    // Sequencer state.
    logic        r_busy, n_busy;
    logic [5:0]  r_pc, n_pc;
    logic [5:0]  r_entry, n_entry;
    logic        r_ramp_act, n_ramp_act;
    logic        r_up, n_up;
    logic signed [10:0] r_val, n_val, r_to, n_to;
    logic [8:0]  r_steer, n_steer, r_turn_tgt, n_turn_tgt, r_pivot, n_pivot;
    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_rank, n_rank;
    logic        r_led, n_led;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic        w_load;
    t_action     r_out_action, n_out_action;
    logic [8:0]  r_out_cmp, n_out_cmp;
    logic [15:0] r_out_hold, n_out_hold;
    logic        r_out_last, n_out_last;
    logic [2:0]  r_out_mode;
    logic [15:0] r_out_rank;
    logic        r_out_led;

    logic        w_accept, w_out_free;
    t_ctrl       w_ctrl;
    logic [7:0]  w_cmd;
    logic        w_obst, w_obst_stop;
    logic [2:0]  w_mode_eff;
    logic [8:0]  w_fwd_trim, w_rev_trim, w_left_trim, w_right_trim;
    logic [9:0]  w_rev_sum, w_right_sum;
    logic [8:0]  w_cmp;
    logic [15:0] w_hold;
    logic signed [10:0] w_ramp_from, w_ramp_to, w_next;
    logic        w_in_range;

    assign w_cmd      = s_axis_tdata[7:0];
    assign w_obst     = s_axis_tdata[8];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_ctrl     = f_ucode(r_pc);

    // Trimmed targets saturate at the ends of the 9-bit range.
    assign w_fwd_trim   = (r_fwd_drive >= TRIM) ? (r_fwd_drive - TRIM) : 9'd0;
    assign w_left_trim  = (r_left_steer >= TRIM) ? (r_left_steer - TRIM) : 9'd0;
    assign w_rev_sum    = {1'b0, r_rev_drive} + {1'b0, TRIM};
    assign w_right_sum  = {1'b0, r_right_steer} + {1'b0, TRIM};
    assign w_rev_trim   = w_rev_sum[9] ? 9'd511 : w_rev_sum[8:0];
    assign w_right_trim = w_right_sum[9] ? 9'd511 : w_right_sum[8:0];

    assign w_turn_prod   = 35'({1'b0, r_turn_ms} + TURN_ROUND) * 35'(TURN_RECIP);
    assign w_turn_scaled = {1'b0, r_turn_q, 6'b0} + {2'b0, r_turn_q, 5'b0}
                         + {5'b0, r_turn_q, 2'b0};

    // The mode seen by the command after any obstacle stop.
    assign w_obst_stop = w_obst && (r_mode == MODE_FORWARD);
    assign w_mode_eff  = w_obst_stop ? MODE_STOP : r_mode;

    always_comb begin
        unique case (w_ctrl.cmp_sel)
            CMP_NEUTRAL:  w_cmp = NEUTRAL_COMPARE;
            CMP_FORWARD:  w_cmp = r_fwd_drive;
            CMP_REVERSE:  w_cmp = r_rev_drive;
            CMP_STEER:    w_cmp = r_steer;
            CMP_FWD_TRIM: w_cmp = w_fwd_trim;
            CMP_REV_TRIM: w_cmp = w_rev_trim;
            default:      w_cmp = 9'd0;
        endcase
        unique case (w_ctrl.hold_sel)
            HOLD_PULSE: w_hold = PULSE_MS;
            HOLD_HORN:  w_hold = HORN_MS;
            HOLD_TURN:  w_hold = r_turn_hold;
            default:    w_hold = 16'd0;
        endcase
        unique case (w_ctrl.ramp_sel)
            RAMP_FROM_TURN: begin
                w_ramp_from = $signed({2'b00, r_turn_tgt});
                w_ramp_to   = $signed({2'b00, NEUTRAL_COMPARE});
            end
            RAMP_TO_PIVOT: begin
                w_ramp_from = $signed({2'b00, NEUTRAL_COMPARE});
                w_ramp_to   = $signed({2'b00, r_pivot});
            end
            default: begin
                w_ramp_from = $signed({2'b00, NEUTRAL_COMPARE});
                w_ramp_to   = $signed({2'b00, r_turn_tgt});
            end
        endcase
    end

    assign w_next     = r_up ? (r_val + RAMP_STEP) : (r_val - RAMP_STEP);
    assign w_in_range = r_up ? (w_next <= r_to) : (w_next >= r_to);

    // Command decode at accept and the per-step sequencer.
    always_comb begin
        n_busy       = r_busy;
        n_pc         = r_pc;
        n_entry      = r_entry;
        n_ramp_act   = r_ramp_act;
        n_up         = r_up;
        n_val        = r_val;
        n_to         = r_to;
        n_steer      = r_steer;
        n_turn_tgt   = r_turn_tgt;
        n_pivot      = r_pivot;
        n_mode       = r_mode;
        n_rank       = r_rank;
        n_led        = r_led;
        w_load       = 1'b0;
        n_out_action = w_ctrl.action;
        n_out_cmp    = w_cmp;
        n_out_hold   = w_hold;
        n_out_last   = 1'b0;

        if (w_accept) begin
            n_busy     = 1'b1;
            n_ramp_act = 1'b0;
            n_mode     = w_mode_eff;
            n_led      = w_obst_stop ^ (w_cmd <= CMD_HORN);
            n_entry    = ENT_REPORT;
            if (w_cmd == CMD_LEFT) begin
                n_steer    = r_left_steer;
                n_turn_tgt = w_left_trim;
                n_pivot    = r_left_pivot;
            end else begin
                n_steer    = r_right_steer;
                n_turn_tgt = w_right_trim;
                n_pivot    = r_right_pivot;
            end
            unique case (w_cmd)
                CMD_STOP: begin
                    n_entry = ENT_STOP;
                    n_mode  = MODE_STOP;
                end
                CMD_FORWARD: begin
                    if (w_mode_eff == MODE_REVERSE) begin
                        n_entry = ENT_STOP;
                        n_mode  = MODE_STOP;
                    end else if (!w_obst) begin
                        n_entry = ENT_FORWARD;
                        n_mode  = MODE_FORWARD;
                    end
                end
                CMD_REVERSE: begin
                    if (w_mode_eff == MODE_REVERSE) begin
                        n_entry = ENT_REVERSE;
                        n_mode  = MODE_STOP;
                    end else if (w_mode_eff == MODE_STOP) begin
                        n_entry = ENT_REVERSE;
                        n_mode  = MODE_REVERSE;
                    end else begin
                        n_entry = ENT_STOP;
                        n_mode  = MODE_STOP;
                    end
                end
                CMD_LEFT, CMD_RIGHT: begin
                    if (w_mode_eff == MODE_FORWARD) begin
                        n_entry = ENT_TURN_FWD;
                    end else if (w_mode_eff == MODE_REVERSE) begin
                        n_entry = ENT_TURN_REV;
                    end else begin
                        n_entry = (w_mode_eff == MODE_STOP && r_rank == 16'd1)
                                ? ENT_PIVOT : ENT_TURN_STILL;
                        n_mode  = (w_cmd == CMD_LEFT) ? MODE_LEFT : MODE_RIGHT;
                    end
                end
                CMD_FASTER: begin
                    n_entry = ENT_FASTER;
                    n_rank  = r_rank + 16'd1;
                end
                CMD_SLOWER: begin
                    n_entry = ENT_SLOWER;
                    n_rank  = r_rank - 16'd1;
                end
                CMD_HORN:    n_entry = ENT_HORN;
                CMD_SPD_RST: n_entry = ENT_SPD_RST;
                default:     n_entry = ENT_REPORT;
            endcase
            n_pc = w_obst_stop ? ENT_PREFIX : n_entry;
        end else if (r_busy) begin
            unique case (w_ctrl.op)
                OP_EMIT: begin
                    if (w_out_free) begin
                        w_load = 1'b1;
                        n_pc   = r_pc + 6'd1;
                    end
                end
                OP_REPORT: begin
                    if (w_out_free) begin
                        w_load     = 1'b1;
                        n_out_last = 1'b1;
                        n_busy     = 1'b0;
                    end
                end
                OP_JUMP: n_pc = r_entry;
                OP_RAMP: begin
                    if (!r_ramp_act) begin
                        n_ramp_act = 1'b1;
                        n_val      = w_ramp_from;
                        n_to       = w_ramp_to;
                        n_up       = w_ramp_from < w_ramp_to;
                    end else if (w_in_range) begin
                        if (w_out_free) begin
                            w_load       = 1'b1;
                            n_out_action = ACT_STEER;
                            n_out_cmp    = w_next[8:0];
                            n_out_hold   = {8'd0, r_ramp_ms};
                            n_val        = w_next;
                        end
                    end else begin
                        n_ramp_act = 1'b0;
                        n_pc       = r_pc + 6'd1;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_drive   <= 9'd310;
            r_rev_drive   <= 9'd190;
            r_left_steer  <= 9'd155;
            r_right_steer <= 9'd335;
            r_left_pivot  <= 9'd130;
            r_right_pivot <= 9'd360;
            r_turn_ms     <= 16'd1600;
            r_ramp_ms     <= 8'd5;
            r_busy        <= 1'b0;
            r_pc          <= ENT_REPORT;
            r_ramp_act    <= 1'b0;
            r_mode        <= MODE_STOP;
            r_rank        <= 16'd1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_FORWARD_DRIVE: r_fwd_drive   <= i_cfg_data[8:0];
                    REG_REVERSE_DRIVE: r_rev_drive   <= i_cfg_data[8:0];
                    REG_LEFT_STEER:    r_left_steer  <= i_cfg_data[8:0];
                    REG_RIGHT_STEER:   r_right_steer <= i_cfg_data[8:0];
                    REG_LEFT_PIVOT:    r_left_pivot  <= i_cfg_data[8:0];
                    REG_RIGHT_PIVOT:   r_right_pivot <= i_cfg_data[8:0];
                    REG_TURN_MS:       r_turn_ms     <= i_cfg_data;
                    REG_RAMP_MS:       r_ramp_ms     <= i_cfg_data[7:0];
                    default:           r_ramp_ms     <= r_ramp_ms;
                endcase
            end
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_ramp_act  <= n_ramp_act;
            r_mode      <= n_mode;
            r_rank      <= n_rank;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge i_clk) begin
        r_turn_q    <= w_turn_prod[33:24];
        r_turn_hold <= w_turn_scaled[16] ? 16'hFFFF : w_turn_scaled[15:0];
        r_entry     <= n_entry;
        r_up        <= n_up;
        r_val       <= n_val;
        r_to        <= n_to;
        r_steer     <= n_steer;
        r_turn_tgt  <= n_turn_tgt;
        r_pivot     <= n_pivot;
        r_led       <= n_led;
        if (w_load) begin
            r_out_action <= n_out_action;
            r_out_cmp    <= n_out_cmp;
            r_out_hold   <= n_out_hold;
            r_out_last   <= n_out_last;
            r_out_mode   <= r_mode;
            r_out_rank   <= r_rank;
            r_out_led    <= r_led;
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out_led, r_out_rank, r_out_mode, r_out_hold, r_out_cmp};

`ifndef SYNTHESIS
    // The run end marker travels only on report items.
    a_last_is_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == ACT_REPORT)))
        else $error("tlast does not match the report action");

    // A taken command starts the sequencer and blocks further commands.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_busy && !s_axis_tready))
        else $error("sequencer did not start after a command");

    // The ramp loop flag is only set while a ramp word is executing.
    a_ramp_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ramp_act) |-> (w_ctrl.op == OP_RAMP))
        else $error("ramp loop active outside a ramp word");

    // Retiring the report word ends the run with a report on the output.
    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_accept && w_ctrl.op == OP_REPORT && w_out_free)
        |=> (!r_busy && m_axis_tvalid && m_axis_tlast))
        else $error("report word did not close the run");
`endif

endmodule
